[hdl/lqh_pkg.sv]
// Shared types and constants for the link quality hysteresis unit.
// No dependencies; used by link_quality_hysteresis_unit and lqh_checker.
`timescale 1ns / 1ps

package lqh_pkg;

    localparam int TIME_BITS_DEFAULT = 24;

    localparam int LEVEL_BITS = 10;
    localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = 10'd1000;

    localparam logic [LEVEL_BITS-1:0] ACCEPT_RESET = 10'd700;
    localparam logic [LEVEL_BITS-1:0] REJECT_RESET = 10'd300;
    localparam logic [LEVEL_BITS-1:0] AGING_RESET  = 10'd250;

    // The aging coefficient approximates aging/1000 in 24 fractional bits.
    // It never falls below the true value and exceeds it by less than 2 LSB,
    // which keeps floor(q * aging / 1000) exact for every 10-bit quality.
    localparam int COEF_FRAC   = 24;
    localparam int COEF_BITS   = 25;
    localparam int RECIP_SHIFT = 10;
    localparam int PROD_BITS   = LEVEL_BITS + COEF_BITS;
    localparam logic [COEF_BITS-1:0] AGE_RECIP = 25'd17179870;
    localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(
        ((64'(AGING_RESET) * 64'(AGE_RECIP)) >> RECIP_SHIFT) + 64'd1);

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        KIND_HELLO = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_ADD   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_ACCEPT = 2'd0,
        REG_REJECT = 2'd1,
        REG_AGING  = 2'd2
    } reg_index_t;

endpackage

[hdl/link_quality_hysteresis_unit.sv]
// A request is registered in the input stage and its result in the result stage.
// Throughput: one request per cycle while the result side does not stall; the link
// state loop (one 10x25 multiply by the registered aging coefficient, a subtract and
// the level compares) is combinational. Reset: rst_n clears the link state to a pending
// link with stopped timer and loads the level registers with 700, 300 and 250; a
// link-added request restores that link state. Depends on lqh_pkg.
`timescale 1ns / 1ps

module link_quality_hysteresis_unit #(
    parameter int TIME_BITS = lqh_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [TIME_BITS-1:0]                hello_interval,
    input  logic [TIME_BITS-1:0]                validity_time,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lqh_pkg::LEVEL_BITS-1:0]      quality,
    output logic                                link_pending,
    output logic                                is_lost,
    output logic                                status_changed,
    output logic                                hello_missed,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lqh_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [lqh_pkg::DATA_BITS-1:0]       pwdata,
    output logic [lqh_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready
);

    localparam int LB = lqh_pkg::LEVEL_BITS;
    localparam int CB = TIME_BITS + 1;

    // configuration registers
    logic [LB-1:0] accept_reg;
    logic [LB-1:0] reject_reg;
    logic [LB-1:0] aging_reg;
    logic [lqh_pkg::COEF_BITS-1:0] coef_reg;
    logic [lqh_pkg::COEF_BITS-1:0] coef_next;
    logic [LB-1:0] w_sat;
    logic [LB-1:0] w_new;
    logic          cfg_write;
    logic [1:0]    cfg_index;

    // input stage
    logic                 in_v_reg;
    logic [1:0]           kind_reg;
    logic [TIME_BITS-1:0] itv_reg;
    logic [TIME_BITS-1:0] vt_reg;
    logic                 accept_in;
    logic                 advance;
    logic                 fire;

    // link state
    logic [LB-1:0]        quality_reg;
    logic [LB-1:0]        quality_next;
    logic                 pending_reg;
    logic                 pending_next;
    logic                 lost_reg;
    logic                 lost_next;
    logic [TIME_BITS-1:0] stored_reg;
    logic [TIME_BITS-1:0] stored_next;
    logic [CB-1:0]        count_reg;
    logic [CB-1:0]        count_next;

    // result stage
    logic          out_v_reg;
    logic [LB-1:0] res_quality_reg;
    logic          res_pending_reg;
    logic          res_lost_reg;
    logic          res_changed_reg;
    logic          res_changed_next;
    logic          res_missed_reg;
    logic          res_missed_next;

    // aging datapath
    logic [lqh_pkg::PROD_BITS-1:0] decay_prod;
    logic [LB-1:0]                 decay;
    logic [LB-1:0]                 aged_q;
    logic [LB:0]                   gained_q;
    logic [TIME_BITS-1:0]          reload;
    logic [CB-1:0]                 count_dec;
    logic                          do_age;
    logic                          age_hello;
    logic [LB-1:0]                 age_q;
    logic                          link_up;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_reg <= lqh_pkg::ACCEPT_RESET;
            reject_reg <= lqh_pkg::REJECT_RESET;
            aging_reg  <= lqh_pkg::AGING_RESET;
            coef_reg   <= lqh_pkg::COEF_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lqh_pkg::REG_ACCEPT: accept_reg <= pwdata[LB-1:0];
                    lqh_pkg::REG_REJECT: reject_reg <= pwdata[LB-1:0];
                    lqh_pkg::REG_AGING:
                    begin
                        aging_reg <= pwdata[LB-1:0];
                        coef_reg  <= coef_next;
                    end
                    default:             ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            lqh_pkg::REG_ACCEPT: prdata = lqh_pkg::DATA_BITS'(accept_reg);
            lqh_pkg::REG_REJECT: prdata = lqh_pkg::DATA_BITS'(reject_reg);
            lqh_pkg::REG_AGING:  prdata = lqh_pkg::DATA_BITS'(aging_reg);
            default:             prdata = '0;
        endcase
    end

    // The aging coefficient is computed from the written value and loaded at the same
    // edge as the aging register, so the two never disagree.
    assign w_sat = (aging_reg > lqh_pkg::MAX_LEVEL) ? lqh_pkg::MAX_LEVEL : aging_reg;
    assign w_new = (pwdata[LB-1:0] > lqh_pkg::MAX_LEVEL) ? lqh_pkg::MAX_LEVEL
                                                          : pwdata[LB-1:0];
    assign coef_next = lqh_pkg::COEF_BITS'(
        ((lqh_pkg::PROD_BITS'(w_new) * lqh_pkg::PROD_BITS'(lqh_pkg::AGE_RECIP))
         >> lqh_pkg::RECIP_SHIFT) + lqh_pkg::PROD_BITS'(1));

    // ------------------------------------------------------------- handshake
    assign advance   = !out_v_reg || !out_stall;
    assign fire      = in_v_reg && advance;
    assign in_stall  = in_v_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
            begin
                in_v_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_v_reg <= 1'b0;
            end
            if (fire)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            kind_reg <= kind;
            itv_reg  <= hello_interval;
            vt_reg   <= validity_time;
        end
    end

    // --------------------------------------------------------------- datapath
    // q * (1000 - w) / 1000 rounded up equals q - floor(q * w / 1000).
    assign decay_prod = lqh_pkg::PROD_BITS'(quality_reg) * lqh_pkg::PROD_BITS'(coef_reg);
    assign decay      = decay_prod[lqh_pkg::COEF_FRAC+LB-1:lqh_pkg::COEF_FRAC];
    assign aged_q     = quality_reg - decay;
    assign gained_q   = {1'b0, aged_q} + {1'b0, w_sat};
    assign age_q      = age_hello ? gained_q[LB-1:0] : aged_q;
    assign link_up    = !pending_reg && !lost_reg;

    assign reload    = (itv_reg != '0) ? itv_reg : vt_reg;
    assign count_dec = count_reg - CB'(1);

    always_comb
    begin
        stored_next      = stored_reg;
        count_next       = count_reg;
        do_age           = 1'b0;
        age_hello        = 1'b0;
        res_missed_next  = 1'b0;
        unique case (kind_reg)
            lqh_pkg::KIND_HELLO:
            begin
                do_age      = 1'b1;
                age_hello   = 1'b1;
                stored_next = reload;
                count_next  = {1'b0, reload} + {2'b00, reload[TIME_BITS-1:1]};
            end
            lqh_pkg::KIND_TICK:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        do_age          = 1'b1;
                        res_missed_next = 1'b1;
                        count_next      = {1'b0, stored_reg};
                    end
                end
            end
            lqh_pkg::KIND_ADD:
            begin
                stored_next = '0;
                count_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        quality_next     = quality_reg;
        pending_next     = pending_reg;
        lost_next        = lost_reg;
        res_changed_next = 1'b0;
        if (kind_reg == lqh_pkg::KIND_ADD)
        begin
            quality_next = '0;
            pending_next = 1'b1;
            lost_next    = 1'b0;
        end
        else if (do_age)
        begin
            quality_next = age_q;
            if (link_up)
            begin
                if (age_q < reject_reg)
                begin
                    lost_next        = 1'b1;
                    res_changed_next = 1'b1;
                end
            end
            else if (age_q > accept_reg)
            begin
                pending_next     = 1'b0;
                lost_next        = 1'b0;
                res_changed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_reg <= '0;
            pending_reg <= 1'b1;
            lost_reg    <= 1'b0;
            stored_reg  <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            quality_reg <= quality_next;
            pending_reg <= pending_next;
            lost_reg    <= lost_next;
            stored_reg  <= stored_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_quality_reg <= quality_next;
            res_pending_reg <= pending_next;
            res_lost_reg    <= lost_next;
            res_changed_reg <= res_changed_next;
            res_missed_reg  <= res_missed_next;
        end
    end

    assign out_valid      = out_v_reg;
    assign quality        = res_quality_reg;
    assign link_pending   = res_pending_reg;
    assign is_lost        = res_lost_reg;
    assign status_changed = res_changed_reg;
    assign hello_missed   = res_missed_reg;

endmodule

[hdl/lqh_checker.sv]
// Port-level checks for link_quality_hysteresis_unit, bound to the top level.
// Depends on lqh_pkg and link_quality_hysteresis_unit.
`timescale 1ns / 1ps

module lqh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [lqh_pkg::LEVEL_BITS-1:0] quality,
    input logic                           link_pending,
    input logic                           is_lost,
    input logic                           status_changed,
    input logic                           hello_missed
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quality) && $stable(link_pending)
            && $stable(is_lost) && $stable(status_changed) && $stable(hello_missed))
        else $error("stalled result changed");

    // A link is never pending and lost at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(link_pending && is_lost))
        else $error("pending and lost both set");

    // Aging keeps the quality within its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quality <= lqh_pkg::MAX_LEVEL)
        else $error("quality out of range");

    // Every status change either brings the link up or loses an up link.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_changed |-> !link_pending)
        else $error("status change left the link pending");

endmodule

bind link_quality_hysteresis_unit lqh_checker u_lqh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .quality        (quality),
    .link_pending   (link_pending),
    .is_lost        (is_lost),
    .status_changed (status_changed),
    .hello_missed   (hello_missed)
);

[tb/link_quality_hysteresis_unit_tb.sv]
// Self-checking testbench for link_quality_hysteresis_unit: a directed script, then random
// requests of all kinds under several level settings, random idling and a long output hold.
// Depends on lqh_pkg and link_quality_hysteresis_unit.
`timescale 1ns / 1ps

module link_quality_hysteresis_unit_tb;

    localparam int TB_TIME_BITS = lqh_pkg::TIME_BITS_DEFAULT;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_REQUESTS = 195;
    localparam int PRINT_LIMIT = 200;
    localparam int SCRIPT_ROWS = 24;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [lqh_pkg::LEVEL_BITS-1:0] quality;
        logic                           pending;
        logic                           lost;
        logic                           changed;
        logic                           missed;
    } link_status_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [TB_TIME_BITS-1:0] interval;
        logic [TB_TIME_BITS-1:0] validity;
        logic                    fixed;
        link_status_t            result;
    } script_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [1:0]                     kind;
    logic [TB_TIME_BITS-1:0]        hello_interval;
    logic [TB_TIME_BITS-1:0]        validity_time;
    logic                           out_valid;
    logic                           out_stall;
    logic [lqh_pkg::LEVEL_BITS-1:0] quality;
    logic                           link_pending;
    logic                           is_lost;
    logic                           status_changed;
    logic                           hello_missed;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lqh_pkg::ADDR_BITS-1:0]  paddr;
    logic [lqh_pkg::DATA_BITS-1:0]  pwdata;
    logic [lqh_pkg::DATA_BITS-1:0]  prdata;
    logic                           pready;

    // Rides along with the payload so the monitor knows which requests carry a typed result.
    logic                           row_fixed;
    link_status_t                   row_result;

    // Shadow of the level registers and of the link state.
    logic [lqh_pkg::LEVEL_BITS-1:0] accept_q;
    logic [lqh_pkg::LEVEL_BITS-1:0] reject_q;
    logic [lqh_pkg::LEVEL_BITS-1:0] aging_q;
    logic [lqh_pkg::LEVEL_BITS-1:0] link_q;
    logic                           pending_q;
    logic                           lost_q;
    logic [TB_TIME_BITS-1:0]        stored_q;
    logic [TB_TIME_BITS:0]          countdown_q;

    link_status_t expected_status[$];
    int           requests_sent = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           hold_requests = 0;
    int           holds_served = 0;
    bit           sender_idle_on = 1'b1;
    bit           receiver_idle_on = 1'b1;

    script_row_t script [SCRIPT_ROWS] = '{
        '{lqh_pkg::KIND_TICK,  24'hFFFFFF, 24'hFFFFFF, 1'b1, '{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{KIND_UNUSED,         24'h000000, 24'h000000, 1'b1, '{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd2,      24'd0,      1'b1, '{10'd250, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd2,      24'd9,      1'b1, '{10'd438, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd0,      24'd4,      1'b1, '{10'd579, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'hFFFFFF, 24'd0,      1'b1, '{10'd685, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd1,      24'd0,      1'b1, '{10'd764, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd573, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{lqh_pkg::KIND_TICK,  24'hAAAAAA, 24'h555555, 1'b1, '{10'd430, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{lqh_pkg::KIND_TICK,  24'h555555, 24'hAAAAAA, 1'b1, '{10'd323, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd243, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd183, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{lqh_pkg::KIND_HELLO, 24'd0,      24'd0,      1'b1, '{10'd388, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd388, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd0,      24'hFFFFFF, 1'b1, '{10'd541, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd3,      24'd0,      1'b1, '{10'd656, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'd3,      24'd0,      1'b1, '{10'd742, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b0, '0},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b0, '0},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b0, '0},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd557, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{lqh_pkg::KIND_ADD,   24'h123456, 24'h654321, 1'b1, '{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_TICK,  24'd0,      24'd0,      1'b1, '{10'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{lqh_pkg::KIND_HELLO, 24'h800001, 24'h7FFFFF, 1'b0, '0}
    };

    link_quality_hysteresis_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .hello_interval (hello_interval),
        .validity_time  (validity_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quality        (quality),
        .link_pending   (link_pending),
        .is_lost        (is_lost),
        .status_changed (status_changed),
        .hello_missed   (hello_missed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_link();
        link_q      = '0;
        pending_q   = 1'b1;
        lost_q      = 1'b0;
        stored_q    = '0;
        countdown_q = '0;
    endfunction

    // One aging step; a received hello adds the weight back. Returns whether the flags moved.
    function automatic logic age_link(input logic heard);
        int unsigned weight;
        int unsigned aged;
        logic        moved;
        weight = (aging_q > lqh_pkg::MAX_LEVEL) ? 1000 : 32'(aging_q);
        aged   = (32'(link_q) * (1000 - weight) + 999) / 1000;
        moved  = 1'b0;
        if (heard)
            aged += weight;
        link_q = lqh_pkg::LEVEL_BITS'(aged);
        if (!pending_q && !lost_q)
        begin
            if (link_q < reject_q)
            begin
                lost_q = 1'b1;
                moved  = 1'b1;
            end
        end
        else if (link_q > accept_q)
        begin
            pending_q = 1'b0;
            lost_q    = 1'b0;
            moved     = 1'b1;
        end
        return moved;
    endfunction

    function automatic link_status_t advance_link(input logic [1:0] k,
                                                  input logic [TB_TIME_BITS-1:0] itv,
                                                  input logic [TB_TIME_BITS-1:0] vt);
        link_status_t st;
        logic         moved;
        logic         missed;
        moved  = 1'b0;
        missed = 1'b0;
        case (k)
            lqh_pkg::KIND_HELLO:
            begin
                moved       = age_link(1'b1);
                stored_q    = (itv != 0) ? itv : vt;
                countdown_q = (TB_TIME_BITS + 1)'((64'(stored_q) * 3) / 2);
            end
            lqh_pkg::KIND_TICK:
            begin
                if (countdown_q != 0)
                begin
                    countdown_q = countdown_q - 1'b1;
                    if (countdown_q == 0)
                    begin
                        missed      = 1'b1;
                        moved       = age_link(1'b0);
                        countdown_q = (TB_TIME_BITS + 1)'(stored_q);
                    end
                end
            end
            lqh_pkg::KIND_ADD:
                clear_link();
            default:
                ;
        endcase
        st.quality = link_q;
        st.pending = pending_q;
        st.lost    = lost_q;
        st.changed = moved;
        st.missed  = missed;
        return st;
    endfunction

    always @(posedge clk)
    begin : result_monitor
        link_status_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                    report_mismatch("result with no request outstanding", 32'(quality), 0);
                else
                begin
                    want = expected_status.pop_front();
                    if (quality !== want.quality)
                        report_mismatch("quality", 32'(quality), 32'(want.quality));
                    if (link_pending !== want.pending)
                        report_mismatch("link_pending", 32'(link_pending), 32'(want.pending));
                    if (is_lost !== want.lost)
                        report_mismatch("is_lost", 32'(is_lost), 32'(want.lost));
                    if (status_changed !== want.changed)
                        report_mismatch("status_changed", 32'(status_changed),
                                        32'(want.changed));
                    if (hello_missed !== want.missed)
                        report_mismatch("hello_missed", 32'(hello_missed), 32'(want.missed));
                end
            end
            if (in_valid && !in_stall)
            begin
                want = advance_link(kind, hello_interval, validity_time);
                if (row_fixed)
                    want = row_result;
                expected_status.push_back(want);
            end
        end
    end

    // Result side: random stalls, or a long hold when the stimulus asks for one.
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                holds_served++;
            end
            else
            begin
                out_stall <= receiver_idle_on && ($urandom_range(99) < 33);
                @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic [1:0] k, input logic [TB_TIME_BITS-1:0] itv,
                                input logic [TB_TIME_BITS-1:0] vt, input logic fixed,
                                input link_status_t res);
        while (sender_idle_on && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        hello_interval <= itv;
        validity_time  <= vt;
        row_fixed      <= fixed;
        row_result     <= res;
        requests_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hellos with mostly short intervals between runs of ticks, so the timer expires often.
    task automatic random_requests(input int count);
        int                      counted;
        int                      pick;
        logic [1:0]              k;
        logic [TB_TIME_BITS-1:0] itv;
        logic [TB_TIME_BITS-1:0] vt;
        counted = 0;
        while (counted < count)
        begin
            pick = $urandom_range(99);
            itv  = TB_TIME_BITS'($urandom);
            vt   = TB_TIME_BITS'($urandom);
            if (pick < 28)
            begin
                k = lqh_pkg::KIND_HELLO;
                case ($urandom_range(9))
                    0:       itv = '0;
                    1, 2:    ;
                    default: itv = TB_TIME_BITS'($urandom_range(1, 5));
                endcase
                if (itv == 0 && $urandom_range(2) != 0)
                    vt = ($urandom_range(3) == 0) ? '0 : TB_TIME_BITS'($urandom_range(1, 5));
            end
            else if (pick < 90)
                k = lqh_pkg::KIND_TICK;
            else if (pick < 95)
                k = lqh_pkg::KIND_ADD;
            else
                k = KIND_UNUSED;
            send_request(k, itv, vt, 1'b0, '0);
            if (k != KIND_UNUSED)
                counted++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen < requests_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic register_write(input lqh_pkg::reg_index_t idx,
                                  input logic [lqh_pkg::LEVEL_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= lqh_pkg::DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            lqh_pkg::REG_ACCEPT: accept_q = value;
            lqh_pkg::REG_REJECT: reject_q = value;
            default:             aging_q  = value;
        endcase
    endtask

    task automatic register_check(input lqh_pkg::reg_index_t idx,
                                  input logic [lqh_pkg::LEVEL_BITS-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[lqh_pkg::LEVEL_BITS-1:0] !== want)
            report_mismatch("register readback", 32'(prdata[lqh_pkg::LEVEL_BITS-1:0]),
                            32'(want));
    endtask

    task automatic check_levels(input logic [lqh_pkg::LEVEL_BITS-1:0] acc,
                                input logic [lqh_pkg::LEVEL_BITS-1:0] rej,
                                input logic [lqh_pkg::LEVEL_BITS-1:0] age);
        register_check(lqh_pkg::REG_ACCEPT, acc);
        register_check(lqh_pkg::REG_REJECT, rej);
        register_check(lqh_pkg::REG_AGING, age);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_levels(input logic [lqh_pkg::LEVEL_BITS-1:0] acc,
                              input logic [lqh_pkg::LEVEL_BITS-1:0] rej,
                              input logic [lqh_pkg::LEVEL_BITS-1:0] age);
        register_write(lqh_pkg::REG_ACCEPT, acc);
        register_write(lqh_pkg::REG_REJECT, rej);
        register_write(lqh_pkg::REG_AGING, age);
        check_levels(acc, rej, age);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = lqh_pkg::KIND_HELLO;
        hello_interval = '0;
        validity_time  = '0;
        row_fixed      = 1'b0;
        row_result     = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        accept_q       = lqh_pkg::ACCEPT_RESET;
        reject_q       = lqh_pkg::REJECT_RESET;
        aging_q        = lqh_pkg::AGING_RESET;
        clear_link();

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_levels(lqh_pkg::ACCEPT_RESET, lqh_pkg::REJECT_RESET, lqh_pkg::AGING_RESET);

        foreach (script[i])
            send_request(script[i].kind, script[i].interval, script[i].validity,
                         script[i].fixed, script[i].result);
        random_requests(PHASE_REQUESTS);
        settle();

        set_levels(10'd1000, 10'd0, 10'd1);
        random_requests(PHASE_REQUESTS);
        settle();

        // Aging above full scale saturates; every hello changes the link status.
        set_levels(10'd0, 10'd1023, 10'd1023);
        random_requests(PHASE_REQUESTS);
        settle();

        // Zero aging freezes the quality.
        set_levels(10'd500, 10'd500, 10'd0);
        random_requests(PHASE_REQUESTS);
        settle();

        set_levels(10'd1023, 10'd1023, 10'd1000);
        random_requests(PHASE_REQUESTS);
        settle();

        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        set_levels(lqh_pkg::LEVEL_BITS'($urandom_range(500, 900)),
                   lqh_pkg::LEVEL_BITS'($urandom_range(100, 499)),
                   lqh_pkg::LEVEL_BITS'($urandom_range(1, 400)));
        random_requests(PHASE_REQUESTS);
        settle();

        // The result side holds off long enough for the unit to stall its request side.
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        set_levels(10'd650, 10'd350, 10'd125);
        hold_requests++;
        random_requests(PHASE_REQUESTS);
        settle();

        if (expected_status.size() != 0)
            report_mismatch("results never returned", expected_status.size(), 0);
        if (mismatches == 0)
            $display("link_quality_hysteresis_unit verification clean");
        else
            $display("link_quality_hysteresis_unit verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("link_quality_hysteresis_unit verification failed");
        $finish;
    end

endmodule
